// ===== rtl/ctp_pkg.sv =====
// Shared types, constants and helpers for the cascaded prescaled timers.
`timescale 1ns / 1ps
`default_nettype none
package ctp_pkg;

	localparam int NUM_TIMERS = 4;
	localparam int COUNT_BITS = 16;
	localparam int PRESC_BITS = 10;
	localparam int DELAY_BITS = 2;
	localparam int IDX_BITS   = 2;
	localparam int DATA_BITS  = 16;
	localparam int MASK_BITS  = 4;

	localparam logic [DELAY_BITS-1:0] START_DELAY = DELAY_BITS'(2);

	// control word bit positions
	localparam int CTL_PRESC_LO = 0;
	localparam int CTL_CASCADE  = 2;
	localparam int CTL_IRQ      = 6;
	localparam int CTL_ENABLE   = 7;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_RELOAD  = 2'd1,
		KIND_CONTROL = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [IDX_BITS-1:0]   timer_index;
		logic [DATA_BITS-1:0]  write_data;
	} cmd_t;

	typedef struct packed {
		logic [DATA_BITS-1:0]  read_data;
		logic [MASK_BITS-1:0]  overflow_mask;
		logic [MASK_BITS-1:0]  irq_mask;
	} res_t;

	// per-cell command, decoded by the top level
	typedef struct packed {
		logic                  tick;
		logic                  wr_reload;
		logic                  wr_ctrl;
		logic [DATA_BITS-1:0]  data;
	} cell_cmd_t;

	// per-cell status toward the top level and the next cell
	typedef struct packed {
		logic                  ovf;
		logic                  irq;
		logic [COUNT_BITS-1:0] count;
	} cell_stat_t;

	// prescaler period: 1, 64, 256 or 1024 ticks
	function automatic logic [PRESC_BITS:0] presc_period(input logic [1:0] sel);
		logic [PRESC_BITS:0] p;
		unique case (sel)
			2'd0: p = (PRESC_BITS+1)'(1);
			2'd1: p = (PRESC_BITS+1)'(64);
			2'd2: p = (PRESC_BITS+1)'(256);
			default: p = (PRESC_BITS+1)'(1024);
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ctp_if.sv =====
// Valid/ready channel interfaces for command items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ctp_cmd_if;
	logic          valid;
	logic          ready;
	ctp_pkg::cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ctp_res_if;
	logic          valid;
	logic          ready;
	ctp_pkg::res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ctp_cell.sv =====
// One timer cell: counter, reload, control, prescaler and start/stop state.
`timescale 1ns / 1ps
`default_nettype none
module ctp_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctp_pkg::cell_cmd_t cmd,
	input  wire logic               carry,
	output ctp_pkg::cell_stat_t     stat
);

	logic [ctp_pkg::COUNT_BITS-1:0] count_q;
	logic [ctp_pkg::COUNT_BITS-1:0] reload_q;
	logic [1:0]                     presc_q;
	logic                           cascade_q;
	logic                           irq_en_q;
	logic                           enable_q;
	logic [ctp_pkg::PRESC_BITS-1:0] pc_q;
	logic [ctp_pkg::DELAY_BITS-1:0] delay_q;
	logic                           stop_q;

	logic [ctp_pkg::PRESC_BITS:0]   pc_inc;
	logic                           pc_hit;
	logic                           self_run;
	logic                           step;
	logic                           all_ones;
	logic                           want;

	assign pc_inc   = {1'b0, pc_q} + (ctp_pkg::PRESC_BITS+1)'(1);
	assign pc_hit   = pc_inc >= ctp_pkg::presc_period(presc_q);
	assign self_run = enable_q && !cascade_q;
	// cascade cells step on the carry from below and ignore the start delay
	assign step     = cmd.tick && enable_q &&
		(cascade_q ? carry : (delay_q == '0 && pc_hit));
	assign all_ones = &count_q;
	assign want     = cmd.data[ctp_pkg::CTL_ENABLE];

	assign stat.ovf   = step && all_ones;
	assign stat.irq   = step && all_ones && irq_en_q;
	assign stat.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			reload_q  <= '0;
			presc_q   <= '0;
			cascade_q <= 1'b0;
			irq_en_q  <= 1'b0;
			enable_q  <= 1'b0;
			pc_q      <= '0;
			delay_q   <= '0;
			stop_q    <= 1'b0;
		end else if (cmd.tick) begin
			if (self_run) begin
				if (delay_q != '0) begin
					delay_q <= delay_q - ctp_pkg::DELAY_BITS'(1);
				end else if (pc_hit) begin
					pc_q <= '0;
				end else begin
					pc_q <= pc_inc[ctp_pkg::PRESC_BITS-1:0];
				end
			end
			if (step) begin
				count_q <= all_ones ? reload_q : count_q + ctp_pkg::COUNT_BITS'(1);
			end
			// pending stop lands at the end of this tick
			if (stop_q) begin
				stop_q   <= 1'b0;
				delay_q  <= '0;
				enable_q <= 1'b0;
			end
		end else if (cmd.wr_reload) begin
			reload_q <= ctp_pkg::COUNT_BITS'(cmd.data);
		end else if (cmd.wr_ctrl) begin
			presc_q   <= cmd.data[ctp_pkg::CTL_PRESC_LO +: 2];
			cascade_q <= cmd.data[ctp_pkg::CTL_CASCADE];
			irq_en_q  <= cmd.data[ctp_pkg::CTL_IRQ];
			if (want) begin
				enable_q <= 1'b1;
				if (!enable_q || stop_q) begin
					count_q <= reload_q;
					pc_q    <= '0;
					delay_q <= ctp_pkg::START_DELAY;
					stop_q  <= 1'b0;
				end
			end else if (enable_q) begin
				stop_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cascaded_prescaled_timers.sv =====
// Top level of the cascaded prescaled timers: command decode, timer chain, result register.
`timescale 1ns / 1ps
`default_nettype none
// Four 16-bit up-counting timers built as a chain of identical cells. Every
// command item is a tick, a reload write, a control write or a counter read,
// and every item produces exactly one result item, registered in the cycle
// after it is accepted. The block takes one item per clock, every clock, as
// long as the result register is empty or being drained in the same cycle. On a tick
// each cell decides locally whether it steps (prescaler or carry from the
// cell below) and hands its overflow to the next cell as that cell's carry,
// so an overflow ripples through the whole chain within the tick's cycle;
// that carry path through all cells sets the clock period. A start (enable
// written high on a stopped timer) reloads the counter and, for a timer that is
// not in cascade mode, skips the next two ticks; a stop counts through one more
// tick before freezing. The overflow and interrupt masks are nonzero only on
// ticks; read data is zero on everything but a read.
module cascaded_prescaled_timers (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ctp_cmd_if.sink     cmd,
	ctp_res_if.source   res
);

	localparam int N = ctp_pkg::NUM_TIMERS;

	logic                 accept;
	logic                 is_tick;
	logic                 in_range;
	ctp_pkg::cell_cmd_t   cell_cmd [N];
	ctp_pkg::cell_stat_t  cell_stat [N];
	logic [N-1:0]         carry;
	logic [N-1:0]         ovf_vec;
	logic [N-1:0]         irq_vec;
	logic [ctp_pkg::DATA_BITS-1:0] rd_mux;
	ctp_pkg::res_t        res_d;

	logic                 res_valid_q;
	ctp_pkg::res_t        res_q;

	// output register frees up when its item is taken in the same cycle
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_tick   = cmd.payload.kind == ctp_pkg::KIND_TICK;
	assign in_range  = 32'(cmd.payload.timer_index) < N;

	assign carry[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic sel;
		assign sel = in_range && (32'(cmd.payload.timer_index) == i);

		assign cell_cmd[i].tick      = accept && is_tick;
		assign cell_cmd[i].wr_reload = accept && sel &&
			cmd.payload.kind == ctp_pkg::KIND_RELOAD;
		assign cell_cmd[i].wr_ctrl   = accept && sel &&
			cmd.payload.kind == ctp_pkg::KIND_CONTROL;
		assign cell_cmd[i].data      = cmd.payload.write_data;

		ctp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cell_cmd[i]),
			.carry  (carry[i]),
			.stat   (cell_stat[i])
		);

		// overflow of this cell is the carry into the next one
		if (i < N - 1) begin : g_carry
			assign carry[i+1] = cell_stat[i].ovf;
		end
		assign ovf_vec[i] = cell_stat[i].ovf;
		assign irq_vec[i] = cell_stat[i].irq;
	end

	// counter read: out-of-range index matches no cell and reads zero
	always_comb begin
		rd_mux = '0;
		for (int i = 0; i < N; i++) begin
			if (32'(cmd.payload.timer_index) == i) begin
				rd_mux = ctp_pkg::DATA_BITS'(cell_stat[i].count);
			end
		end
	end

	always_comb begin
		res_d.read_data     = (cmd.payload.kind == ctp_pkg::KIND_READ) ? rd_mux : '0;
		res_d.overflow_mask = is_tick ? ctp_pkg::MASK_BITS'(ovf_vec) : '0;
		res_d.irq_mask      = is_tick ? ctp_pkg::MASK_BITS'(irq_vec) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	// every accepted item leaves a result in the output register
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted item produced no result");

	// interrupts are only raised by timers that overflowed
	a_irq_within_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.payload.irq_mask & ~res.payload.overflow_mask) == '0)
		else $error("irq bit without overflow");

	// accesses never report overflows
	a_access_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_tick) |=> res.payload.overflow_mask == '0)
		else $error("overflow reported on an access");

	// no cell overflows unless a tick is being accepted
	a_carry_from_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && is_tick) |-> ovf_vec == '0)
		else $error("overflow without a tick");

endmodule
`default_nettype wire
